>>> hw/rtl/sbox_linear_approx_entry_assert.svh
// ---------------------------------------------------------------------------
// S-box linear approximation entry - assertion macros
// Shared property forms for the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef SBOX_LINEAR_APPROX_ENTRY_ASSERT_SVH
`define SBOX_LINEAR_APPROX_ENTRY_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sla_pkg.sv
// ---------------------------------------------------------------------------
// S-box linear approximation entry - package
// Opcodes, controller states and the command/status groups.
// ---------------------------------------------------------------------------
package sla_pkg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        SLA_IDLE,
        SLA_SCAN,
        SLA_TAIL,
        SLA_EMIT
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic addr_last;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/sla_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sla_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sla_ctrl.sv
// ---------------------------------------------------------------------------
// S-box linear approximation entry - controller
// Sequences table writes, the table scan of a query and the result hand-off.
// ---------------------------------------------------------------------------
`include "sbox_linear_approx_entry_assert.svh"

module sla_ctrl #(
    parameter int SBOX_BITS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            opcode,
    output logic            s_tready,
    input  sla_pkg::sts_t   sts,
    output sla_pkg::cmd_t   cmd
);

    localparam int ENTRY_COUNT = 1 << SBOX_BITS;

    sla_pkg::state_t state_reg;
    sla_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sla_pkg::SLA_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sla_pkg::SLA_IDLE: begin
                if (s_tvalid && opcode == sla_pkg::OP_QUERY) begin
                    state_next = sla_pkg::SLA_SCAN;
                end
            end
            sla_pkg::SLA_SCAN: begin
                if (sts.addr_last) begin
                    state_next = sla_pkg::SLA_TAIL;
                end
            end
            sla_pkg::SLA_TAIL: begin
                state_next = sla_pkg::SLA_EMIT;
            end
            sla_pkg::SLA_EMIT: begin
                if (sts.out_free) begin
                    state_next = sla_pkg::SLA_IDLE;
                end
            end
            default: begin
                state_next = sla_pkg::SLA_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            sla_pkg::SLA_IDLE: begin
                s_tready  = 1'b1;
                cmd.wr_en = s_tvalid && opcode == sla_pkg::OP_WRITE;
                cmd.start = s_tvalid && opcode == sla_pkg::OP_QUERY;
            end
            sla_pkg::SLA_SCAN: begin
                cmd.scan = 1'b1;
            end
            sla_pkg::SLA_TAIL: begin
                cmd = '0;
            end
            sla_pkg::SLA_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `SLA_ASSERT_NOW(a_start_reaches_emit, cmd.start, ##(ENTRY_COUNT + 2) (state_reg == sla_pkg::SLA_EMIT), "query did not reach emit after full scan")
    `SLA_ASSERT_NOW(a_no_write_in_scan, cmd.wr_en, state_reg == sla_pkg::SLA_IDLE && !cmd.scan, "table write during a scan")
    `SLA_ASSERT_NEXT(a_scan_end, state_reg == sla_pkg::SLA_SCAN && sts.addr_last, !cmd.scan && !s_tready, "scan overran the table")

endmodule

>>> hw/rtl/sla_dp.sv
// ---------------------------------------------------------------------------
// S-box linear approximation entry - datapath
// Table RAM, scan address, parity match counter and the result register.
// ---------------------------------------------------------------------------
`include "sbox_linear_approx_entry_assert.svh"

module sla_dp #(
    parameter int SBOX_BITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [SBOX_BITS-1:0]        entry_index,
    input  logic [SBOX_BITS-1:0]        entry_value,
    input  logic [SBOX_BITS-1:0]        input_mask,
    input  logic [SBOX_BITS-1:0]        output_mask,
    input  sla_pkg::cmd_t               cmd,
    output sla_pkg::sts_t               sts,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic signed [SBOX_BITS:0]   bias
);

    localparam int ENTRY_COUNT = 1 << SBOX_BITS;
    localparam int CNT_W       = SBOX_BITS + 1;
    localparam logic [CNT_W-1:0] HALF = CNT_W'(ENTRY_COUNT / 2);

    logic [SBOX_BITS-1:0]     addr_reg;
    logic [SBOX_BITS-1:0]     addr_next;
    logic [SBOX_BITS-1:0]     x_reg;
    logic                     rd_valid_reg;
    logic [SBOX_BITS-1:0]     amask_reg;
    logic [SBOX_BITS-1:0]     bmask_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic signed [CNT_W-1:0]  bias_reg;
    logic [SBOX_BITS-1:0]     rdata;
    logic                     match;

    sla_ram #(
        .WIDTH (SBOX_BITS),
        .DEPTH (ENTRY_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (entry_index),
        .wdata (entry_value),
        .re    (cmd.scan),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign match = (^(amask_reg & x_reg)) == (^(bmask_reg & rdata));

    always_comb begin
        addr_next = addr_reg;
        if (cmd.start) begin
            addr_next = '0;
        end else if (cmd.scan) begin
            addr_next = addr_reg + SBOX_BITS'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.start) begin
            count_next = '0;
        end else if (rd_valid_reg && match) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            addr_reg     <= '0;
        end else begin
            rd_valid_reg <= cmd.scan;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= addr_reg;
        if (cmd.start) begin
            amask_reg <= input_mask;
            bmask_reg <= output_mask;
        end
        if (cmd.emit) begin
            bias_reg <= signed'(count_reg - HALF);
        end
    end

    assign sts.addr_last = addr_reg == {SBOX_BITS{1'b1}};
    assign sts.out_free  = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign bias          = bias_reg;

    `SLA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRY_COUNT), "match count beyond table size")
    `SLA_ASSERT_NEXT(a_emit_valid, cmd.emit, m_valid_reg, "result register not loaded on emit")
    `SLA_ASSERT_NOW(a_emit_free, cmd.emit, !m_valid_reg || m_tready, "result overwritten while stalled")

endmodule

>>> hw/rtl/sbox_linear_approx_entry.sv
// ---------------------------------------------------------------------------
// S-box linear approximation entry
// Stores an S-box and returns the linear approximation bias for a mask pair.
// ---------------------------------------------------------------------------
// Input channel s_*: one request per beat. s_tuser is the opcode: write
// stores entry_value at entry_index and returns nothing; query returns the
// bias of input_mask / output_mask over all 2^SBOX_BITS entries.
// Output channel m_*: one bias per query, signed, zero-padded in m_tdata.
// A write stores its entry in idle; the next request is accepted on the next cycle.
// A query scans the whole table before m_tvalid rises: the table RAM has one
// read port, so the scan state reads one entry per cycle, then a tail state
// waits for the registered read of the last entry and the emit state loads the
// result. s_tready rises in the same cycle as m_tvalid, so a new request is not
// taken until the earlier query has left the emit state.
// The result waits in an output register, so s_tready returns as soon as it
// is loaded. If the receiver stalls, a second query completes its scan and
// holds in its final state until the output register empties.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any pending result; the S-box contents are not cleared and must be written
// before they are queried.
// ---------------------------------------------------------------------------
module sbox_linear_approx_entry #(
    parameter int SBOX_BITS = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // entry_index, entry_value, input_mask, output_mask (lowest bit up)
    input  logic [((4 * SBOX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // bias (signed)
    output logic [((SBOX_BITS + 8) / 8) * 8 - 1:0] m_tdata
);

    localparam int M_TDATA_W = ((SBOX_BITS + 8) / 8) * 8;

    sla_pkg::cmd_t cmd;
    sla_pkg::sts_t sts;
    logic signed [SBOX_BITS:0] bias;

    sla_ctrl #(
        .SBOX_BITS (SBOX_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sla_dp #(
        .SBOX_BITS (SBOX_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_index (s_tdata[SBOX_BITS-1:0]),
        .entry_value (s_tdata[2*SBOX_BITS-1:SBOX_BITS]),
        .input_mask  (s_tdata[3*SBOX_BITS-1:2*SBOX_BITS]),
        .output_mask (s_tdata[4*SBOX_BITS-1:3*SBOX_BITS]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .bias        (bias)
    );

    assign m_tdata = M_TDATA_W'(unsigned'(bias));

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// S-box linear approximation entry - testbench
// Loads the S-box through write requests and checks the bias returned for
// each mask query against a local prediction of the table, with random gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SBOX_BITS    = 4;
    localparam int ENTRIES      = 1 << SBOX_BITS;
    localparam int S_W          = ((4 * SBOX_BITS + 7) / 8) * 8;
    localparam int M_W          = ((SBOX_BITS + 8) / 8) * 8;
    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
    localparam int REPORT_LIMIT = 10;

    class bias_scoreboard;
        logic [SBOX_BITS-1:0] sbox_copy[ENTRIES];
        logic [SBOX_BITS:0]   expected_bias[$];
        int                   errors;
        int                   reported;

        function logic [SBOX_BITS:0] predict_bias(logic [SBOX_BITS-1:0] amask,
                                                  logic [SBOX_BITS-1:0] bmask);
            int                   match_count;
            int                   diff;
            logic [SBOX_BITS-1:0] xv;
            match_count = 0;
            for (int x = 0; x < ENTRIES; x++) begin
                xv = x[SBOX_BITS-1:0];
                if (^(amask & xv) == ^(bmask & sbox_copy[x]))
                    match_count++;
            end
            diff = match_count - ENTRIES / 2;
            return diff[SBOX_BITS:0];
        endfunction

        function void note_request(sla_pkg::opcode_t op, logic [S_W-1:0] data);
            logic [SBOX_BITS-1:0] idx;
            logic [SBOX_BITS-1:0] val;
            logic [SBOX_BITS-1:0] amask;
            logic [SBOX_BITS-1:0] bmask;
            idx   = data[0 +: SBOX_BITS];
            val   = data[SBOX_BITS +: SBOX_BITS];
            amask = data[2 * SBOX_BITS +: SBOX_BITS];
            bmask = data[3 * SBOX_BITS +: SBOX_BITS];
            if (op == sla_pkg::OP_WRITE) begin
                sbox_copy[idx] = val;
            end else begin
                expected_bias.push_back(predict_bias(amask, bmask));
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (reported < REPORT_LIMIT) begin
                reported++;
                $display("%s", msg);
            end
        endfunction

        function void check_bias(logic [M_W-1:0] tdata);
            logic [SBOX_BITS:0] got;
            logic [SBOX_BITS:0] want;
            got = tdata[SBOX_BITS:0];
            if (expected_bias.size() == 0) begin
                flag($sformatf("bias %0d returned with no query pending", $signed(got)));
            end else begin
                want = expected_bias.pop_front();
                if (got !== want)
                    flag($sformatf("bias mismatch: expected %0d, got %0d",
                                   $signed(want), $signed(got)));
            end
        endfunction
    endclass

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    bias_scoreboard tracker = new();
    bit             quiet   = 1'b0;
    int             sent    = 0;
    int             hold_left;
    int             cycles  = 0;

    sbox_linear_approx_entry #(
        .SBOX_BITS(SBOX_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(21, 80);
    endfunction

    task automatic send_request(sla_pkg::opcode_t op, logic [S_W-1:0] data);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(op, data);
        sent++;
    endtask

    task automatic write_entry(logic [SBOX_BITS-1:0] idx, logic [SBOX_BITS-1:0] val);
        logic [SBOX_BITS-1:0] amask;
        logic [SBOX_BITS-1:0] bmask;
        amask = SBOX_BITS'($urandom_range(0, ENTRIES - 1));
        bmask = SBOX_BITS'($urandom_range(0, ENTRIES - 1));
        send_request(sla_pkg::OP_WRITE, {bmask, amask, val, idx});
    endtask

    task automatic query_bias(logic [SBOX_BITS-1:0] amask, logic [SBOX_BITS-1:0] bmask);
        logic [SBOX_BITS-1:0] idx;
        logic [SBOX_BITS-1:0] val;
        idx = SBOX_BITS'($urandom_range(0, ENTRIES - 1));
        val = SBOX_BITS'($urandom_range(0, ENTRIES - 1));
        send_request(sla_pkg::OP_QUERY, {bmask, amask, val, idx});
    endtask

    task automatic load_table();
        logic [SBOX_BITS-1:0] offset;
        bit                   affine;
        offset = SBOX_BITS'($urandom_range(0, ENTRIES - 1));
        affine = 1'($urandom_range(0, 1));
        for (int x = 0; x < ENTRIES; x++) begin
            if (affine)
                write_entry(x[SBOX_BITS-1:0], x[SBOX_BITS-1:0] ^ offset);
            else
                write_entry(x[SBOX_BITS-1:0], SBOX_BITS'($urandom_range(0, ENTRIES - 1)));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                tracker.check_bias(m_tdata);
            if (quiet) begin
                m_tready  <= 1'b1;
                hold_left <= 0;
            end else if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready  <= 1'b0;
                hold_left <= pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every entry before the first query
        for (int x = 0; x < ENTRIES; x++)
            write_entry(x[SBOX_BITS-1:0], x[SBOX_BITS-1:0] ^ {SBOX_BITS{1'b1}});
        query_bias('0, '0);
        query_bias(SBOX_BITS'(1), SBOX_BITS'(1));
        query_bias('1, '1);
        query_bias('1, '0);
        query_bias('0, '1);

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 49) == 0)
                quiet = !quiet;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                load_table();
            else if (pick < 35)
                write_entry(SBOX_BITS'($urandom_range(0, ENTRIES - 1)),
                            SBOX_BITS'($urandom_range(0, ENTRIES - 1)));
            else
                query_bias(SBOX_BITS'($urandom_range(0, ENTRIES - 1)),
                           SBOX_BITS'($urandom_range(0, ENTRIES - 1)));
        end
        s_tvalid <= 1'b0;

        while (tracker.expected_bias.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_bias.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
